[sv/deq_pkg.sv]
// Shared types and constants for the double-ended queue block.
// Used by deq_cell, deq_scan and double_ended_queue; depends on nothing.
package deq_pkg;

  // Operation codes carried in the input word.
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_SEARCH     = 3'd4;

  // Status codes carried in the result word.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // The search scanner inspects this many match flags per cycle.
  localparam int SCAN_LANES = 8;
  localparam int SCAN_SEL_W = 3;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value_in;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic               found;
    logic [3:0]         found_position;
    logic [1:0]         status;
    logic               is_empty;
    logic [4:0]         occupancy;
  } deq_out_t;

  // Broadcast shift control for the row of cells.
  typedef struct packed {
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

  // Report from the search scanner back to the controller.
  typedef struct packed {
    logic       done;
    logic       found;
    logic [3:0] position;
  } scan_res_t;

  // Index of the lowest set flag in one group of scan lanes.
  function automatic logic [SCAN_SEL_W-1:0] first_set(input logic [SCAN_LANES-1:0] flags);
    logic [SCAN_SEL_W-1:0] sel;
    sel = '0;
    for (int i = SCAN_LANES - 1; i >= 0; i--) begin
      if (flags[i]) begin
        sel = SCAN_SEL_W'(i);
      end
    end
    return sel;
  endfunction

endpackage

[sv/deq_cell.sv]
// One storage cell of the deque shift chain.
// Depends on deq_pkg for the shift control struct.
module deq_cell (
  input  logic                clk,
  input  deq_pkg::cell_ctrl_t ctrl,
  input  logic                write_en,
  input  logic signed [31:0]  prev_val,
  input  logic signed [31:0]  next_val,
  input  logic signed [31:0]  in_val,
  output logic signed [31:0]  value,
  output logic                match
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctrl.take_prev) begin
      value_nxt = prev_val;
    end else if (ctrl.take_next) begin
      value_nxt = next_val;
    end else if (write_en) begin
      value_nxt = in_val;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = (value_r == in_val);

endmodule

[sv/deq_scan.sv]
// Search scanner: walks the registered match flags one lane group per cycle
// and reports the first hit. Depends on deq_pkg for first_set and scan_res_t.
module deq_scan #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DEPTH-1:0]             hits,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output deq_pkg::scan_res_t           res
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SCAN_W = ((DEPTH + deq_pkg::SCAN_LANES - 1) / deq_pkg::SCAN_LANES)
                          * deq_pkg::SCAN_LANES;
  localparam int BASE_W = $clog2(SCAN_W + 1);

  logic [SCAN_W-1:0] hits_r;
  logic [BASE_W-1:0] base_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;

  logic [deq_pkg::SCAN_LANES-1:0] chunk;
  logic                           any_hit;
  logic [BASE_W:0]                reach;
  logic                           last_group;
  logic [BASE_W-1:0]              pos_full;

  always_comb begin
    chunk      = hits_r[deq_pkg::SCAN_LANES-1:0];
    any_hit    = |chunk;
    reach      = (BASE_W+1)'(base_r) + (BASE_W+1)'(deq_pkg::SCAN_LANES);
    last_group = reach >= (BASE_W+1)'(cnt_r);
    pos_full   = base_r + BASE_W'(deq_pkg::first_set(chunk));

    res.done     = busy_r && (any_hit || last_group);
    res.found    = busy_r && any_hit;
    res.position = any_hit ? 4'(pos_full) : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (res.done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hits_r <= SCAN_W'(hits);
      base_r <= '0;
      cnt_r  <= count;
    end else if (busy_r && !res.done) begin
      hits_r <= hits_r >> deq_pkg::SCAN_LANES;
      base_r <= BASE_W'(reach);
    end
  end

endmodule

[sv/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values built as a shift chain.
// Depends on deq_pkg, deq_cell and deq_scan.
//
// Usage: one input word carries an operation and a value; each accepted word
// yields exactly one result word. Both channels use valid/ready handshakes.
// Push back, push front, pop front and pop back complete at the accepting
// edge: the result word appears on out_valid in the next cycle, so these
// operations sustain one word per cycle while the receiver keeps taking them.
// The front of the queue always sits in cell 0; a push at the front shifts
// every cell one place toward the back, a pop at the front shifts one place
// toward the front, and pushes and pops at the back touch only the tail cell.
// A search compares all cells against the key combinationally and then scans
// the registered match flags eight cells per cycle, so it occupies the block
// until the scan reaches the first hit or the end of the live cells.
// The output register parts the two sides: a new word is taken while the
// previous result is being taken, but not while it is still stalled.
// Reset clears the occupancy count, the output valid flag and the search state;
// cell contents are left alone since only cells below the count are ever read.
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  deq_pkg::deq_out_t  out_data_r, out_data_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic                 in_fire;
  logic                 full;
  logic                 empty;
  deq_pkg::cell_ctrl_t  cell_ctrl;
  logic                 push_back_go;
  logic                 scan_start;
  logic [DEPTH-1:0]     write_en;
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     hits;
  logic signed [31:0]   cell_val [DEPTH];
  logic signed [31:0]   back_val;
  deq_pkg::scan_res_t   scan_res;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Per-cell decodes: the tail slot for a push at the back, the live-cell
  // mask for search hits, and the last live cell for a pop at the back.
  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      write_en[i] = push_back_go && (CNT_W'(i) == count_r);
      hits[i]     = match[i] && (CNT_W'(i) < count_r);
      if (CNT_W'(i + 1) == count_r) begin
        back_val = back_val | cell_val[i];
      end
    end
  end

  // Operation decode and the next state of the controller.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    count_nxt     = count_r;
    cell_ctrl     = '0;
    push_back_go  = 1'b0;
    scan_start    = 1'b0;

    if (in_fire) begin
      out_data_nxt  = '0;
      out_valid_nxt = 1'b1;
      case (in_data.operation)
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            out_data_nxt.status = deq_pkg::STAT_FULL;
          end else begin
            push_back_go = 1'b1;
            count_nxt    = count_r + CNT_W'(1);
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            out_data_nxt.status = deq_pkg::STAT_FULL;
          end else begin
            cell_ctrl.take_prev = 1'b1;
            count_nxt           = count_r + CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            out_data_nxt.status = deq_pkg::STAT_EMPTY;
          end else begin
            out_data_nxt.value_out = cell_val[0];
            cell_ctrl.take_next    = 1'b1;
            count_nxt              = count_r - CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            out_data_nxt.status = deq_pkg::STAT_EMPTY;
          end else begin
            out_data_nxt.value_out = back_val;
            count_nxt              = count_r - CNT_W'(1);
          end
        end
        deq_pkg::OP_SEARCH: begin
          // The result waits until the scanner has walked the match flags.
          scan_start    = 1'b1;
          out_valid_nxt = 1'b0;
          state_nxt     = ST_SEARCH;
        end
        default: begin
        end
      endcase
      out_data_nxt.is_empty  = (count_nxt == '0);
      out_data_nxt.occupancy = 5'(count_nxt);
    end else if (state_r == ST_SEARCH && scan_res.done) begin
      // The output register is known to be empty here: it was drained when
      // the search word was accepted and nothing else has written it since.
      out_data_nxt                = '0;
      out_data_nxt.found          = scan_res.found;
      out_data_nxt.found_position = scan_res.position;
      out_data_nxt.is_empty       = empty;
      out_data_nxt.occupancy      = 5'(count_r);
      out_valid_nxt               = 1'b1;
      state_nxt                   = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The row of cells. Cell 0 takes the pushed word when the chain shifts
  // toward the back; the last cell keeps its own word when it shifts forward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_v;
    logic signed [31:0] next_v;

    if (i == 0) begin : g_head
      assign prev_v = in_data.value_in;
    end else begin : g_mid_prev
      assign prev_v = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_v = cell_val[i];
    end else begin : g_mid_next
      assign next_v = cell_val[i+1];
    end

    deq_cell u_cell (
      .clk      (clk),
      .ctrl     (in_fire ? cell_ctrl : '0),
      .write_en (write_en[i]),
      .prev_val (prev_v),
      .next_val (next_v),
      .in_val   (in_data.value_in),
      .value    (cell_val[i]),
      .match    (match[i])
    );
  end

  deq_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .hits  (hits),
    .count (count_r),
    .res   (scan_res)
  );

  // The count never passes the capacity of the chain.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy count exceeds depth");

  // A search result is never presented in the cycle after the search is taken.
  a_search_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.operation == deq_pkg::OP_SEARCH |=> !out_valid)
    else $error("search result shown before the scan ran");

  // Each accepted word moves the count by at most one entry.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1))
                || (count_r == $past(count_r) - CNT_W'(1)))
    else $error("occupancy moved by more than one");

  // A pop that found nothing always reports an empty queue.
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == deq_pkg::STAT_EMPTY |-> out_data.is_empty)
    else $error("empty status with entries held");

  // A hit is only ever reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.status == deq_pkg::STAT_OK)
    else $error("search hit reported with error status");

endmodule

[sim/tb_double_ended_queue.sv]
// Self-checking testbench for the double_ended_queue block.
// Depends on deq_pkg for the word types and operation and status codes.
// Each result word is checked against a queue model kept in the bench.
module tb_double_ended_queue;

  localparam int QDEPTH          = 16;
  localparam int IDX_W           = $clog2(QDEPTH);
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_WORDS  = 40;
  localparam int RANDOM_WORDS    = 1500;
  localparam int MAX_PRINTED     = 40;
  localparam int TAIL_CYCLES     = 20;

  // The operation field is three bits wide, so codes above search exist but do nothing.
  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  // The random mix leans toward filling, draining or neither, so that both the full
  // and the empty ends of the queue are reached often.
  typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  deq_pkg::deq_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  deq_pkg::deq_out_t out_data;

  // Model of the queue contents. The front is entry 0, as in the block.
  logic signed [31:0] model_cells [QDEPTH];
  int                 model_fill;

  // Result words that are predicted but not yet taken from the block, oldest first.
  deq_pkg::deq_out_t pending_results [$];

  int mismatch_count;
  int idle_cycles;
  bit src_steady;
  bit sink_steady;
  int sink_hold_request;
  int sink_stall_left;

  double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Most gaps are zero or short. A few are long, so that stalls fall on every phase
  // of a search and on a full output register.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A quarter of the values come from a small pool around zero. This gives duplicate
  // entries, so a search has to return the first match and not just any match.
  function automatic logic signed [31:0] random_value();
    if ($urandom_range(0, 3) == 0) return $signed(32'($urandom_range(0, 4))) - 32'sd2;
    return $urandom;
  endfunction

  // Applies one accepted word to the model and returns the result word the block
  // should produce for it. Fields that the operation does not use stay zero.
  function automatic deq_pkg::deq_out_t predict_deque_result(input deq_pkg::deq_in_t w);
    deq_pkg::deq_out_t r;
    int i;
    r = '0;
    case (w.operation)
      deq_pkg::OP_PUSH_BACK: begin
        if (model_fill >= QDEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else begin
          model_cells[IDX_W'(model_fill)] = w.value_in;
          model_fill++;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (model_fill >= QDEPTH) begin
          r.status = deq_pkg::STAT_FULL;
        end else begin
          for (i = model_fill; i > 0; i--) model_cells[IDX_W'(i)] = model_cells[IDX_W'(i-1)];
          model_cells[0] = w.value_in;
          model_fill++;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (model_fill == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
        end else begin
          r.value_out = model_cells[0];
          for (i = 0; i < model_fill - 1; i++) begin
            model_cells[IDX_W'(i)] = model_cells[IDX_W'(i+1)];
          end
          model_fill--;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (model_fill == 0) begin
          r.status = deq_pkg::STAT_EMPTY;
        end else begin
          model_fill--;
          r.value_out = model_cells[IDX_W'(model_fill)];
        end
      end
      deq_pkg::OP_SEARCH: begin
        for (i = 0; i < model_fill; i++) begin
          if (!r.found && model_cells[IDX_W'(i)] == w.value_in) begin
            r.found          = 1'b1;
            r.found_position = 4'(i);
          end
        end
      end
      default: begin
      end
    endcase
    r.is_empty  = (model_fill == 0);
    r.occupancy = 5'(model_fill);
    return r;
  endfunction

  // Prints one line for each mismatch. Only the first few are printed, so that a
  // broken block cannot flood the log. Every mismatch is counted.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Offers one word after an optional random gap. The task returns at the edge that
  // accepts the word, with in_valid still high. A word that follows at once then keeps
  // valid high, and in_valid gets only one assignment in any time step.
  task automatic offer_word(input logic [2:0] op, input logic signed [31:0] value);
    int gap;
    deq_pkg::deq_in_t w;
    w.operation = op;
    w.value_in  = value;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_deque_result(w));
  endtask

  // Lowers valid and lets one edge pass. The next word then starts in a later time step.
  task automatic source_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The sender pauses until the block has returned every predicted result.
  task automatic wait_for_results();
    source_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Picks a random word. The choice of operation follows the current lean. Most search
  // keys are taken from the model, so that hits occur at every position.
  function automatic deq_pkg::deq_in_t random_word(input lean_t lean);
    deq_pkg::deq_in_t w;
    int r;
    int push_w;
    int pop_w;
    case (lean)
      LEAN_FILL: begin
        push_w = 55;
        pop_w  = 23;
      end
      LEAN_DRAIN: begin
        push_w = 23;
        pop_w  = 55;
      end
      default: begin
        push_w = 39;
        pop_w  = 39;
      end
    endcase
    w.value_in = random_value();
    r = $urandom_range(0, 99);
    if (r < push_w) begin
      w.operation = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
    end else if (r < push_w + pop_w) begin
      w.operation = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    end else if (r < 98) begin
      w.operation = deq_pkg::OP_SEARCH;
      if (model_fill > 0 && $urandom_range(0, 99) < 65) begin
        w.value_in = model_cells[IDX_W'($urandom_range(0, model_fill - 1))];
      end
    end else begin
      w.operation = 3'(OP_UNUSED_5 + $urandom_range(0, 2));
    end
    return w;
  endfunction

  // Receiver side. After each ready cycle it may start a random stall. A hold-off
  // that a test asks for is counted here, cycle by cycle, while the sender keeps
  // offering words.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready       <= 1'b0;
      sink_stall_left = 0;
    end else if (sink_stall_left > 0) begin
      out_ready <= 1'b0;
      sink_stall_left--;
    end else if (sink_hold_request > 0) begin
      out_ready         <= 1'b0;
      sink_stall_left   = sink_hold_request - 1;
      sink_hold_request = 0;
    end else begin
      out_ready       <= 1'b1;
      sink_stall_left = sink_steady ? 0 : pick_gap();
    end
  end

  // Every result word taken from the block is compared field by field with the oldest
  // prediction. A result word with no prediction waiting is a failure too.
  always @(posedge clk) begin : result_check
    deq_pkg::deq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, occupancy", out_data.occupancy, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.value_out !== want.value_out)
          report_mismatch("value_out", out_data.value_out, want.value_out);
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.found_position !== want.found_position)
          report_mismatch("found_position", out_data.found_position, want.found_position);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.is_empty !== want.is_empty)
          report_mismatch("is_empty", out_data.is_empty, want.is_empty);
        if (out_data.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_data.occupancy, want.occupancy);
      end
    end
  end

  // The watchdog ends the run if no word moves on either channel for too long. The
  // longest correct quiet stretch is the receiver hold-off, which is far below the limit.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Pops, a search and the unused codes on an empty queue. The unused codes must
  // still report empty and zero occupancy.
  task automatic test_empty_queue();
    offer_word(deq_pkg::OP_POP_FRONT, $urandom);
    offer_word(deq_pkg::OP_POP_BACK, $urandom);
    offer_word(deq_pkg::OP_SEARCH, 32'sd0);
    offer_word(OP_UNUSED_5, $urandom);
    offer_word(OP_UNUSED_6, $urandom);
    offer_word(OP_UNUSED_7, $urandom);
  endtask

  // Extreme values pushed at both ends. Searches then hit at the front, at the middle
  // and at the back, and one search misses. A duplicate of the front value checks
  // that the first match wins. Pops from both ends empty the queue, and one more pop
  // finds it empty.
  task automatic test_directed_ops();
    offer_word(deq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
    offer_word(deq_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF);
    offer_word(deq_pkg::OP_PUSH_FRONT, 32'sd0);
    offer_word(deq_pkg::OP_PUSH_FRONT, -32'sd1);
    offer_word(deq_pkg::OP_SEARCH, 32'sh7FFF_FFFF);
    offer_word(deq_pkg::OP_SEARCH, 32'sh8000_0000);
    offer_word(deq_pkg::OP_SEARCH, -32'sd1);
    offer_word(deq_pkg::OP_SEARCH, 32'sd1);
    offer_word(deq_pkg::OP_PUSH_BACK, -32'sd1);
    offer_word(deq_pkg::OP_SEARCH, -32'sd1);
    offer_word(OP_UNUSED_7, -32'sd1);
    offer_word(deq_pkg::OP_POP_BACK, $urandom);
    offer_word(deq_pkg::OP_POP_FRONT, $urandom);
    offer_word(deq_pkg::OP_POP_FRONT, $urandom);
    offer_word(deq_pkg::OP_POP_BACK, $urandom);
    offer_word(deq_pkg::OP_POP_BACK, $urandom);
    offer_word(deq_pkg::OP_POP_BACK, $urandom);
  endtask

  // Fills the queue from both ends with random values. Pushes at both ends while it is
  // full must be refused. Searches hit the last and the first entry. The queue is then
  // drained from random ends until a pop finds it empty.
  task automatic test_fill_and_drain();
    while (model_fill < QDEPTH) begin
      offer_word($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                 $urandom);
    end
    offer_word(deq_pkg::OP_PUSH_BACK, $urandom);
    offer_word(deq_pkg::OP_PUSH_FRONT, $urandom);
    offer_word(deq_pkg::OP_SEARCH, model_cells[QDEPTH-1]);
    offer_word(deq_pkg::OP_SEARCH, model_cells[0]);
    offer_word(OP_UNUSED_6, $urandom);
    while (model_fill > 0) begin
      offer_word($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                 $urandom);
    end
    offer_word(deq_pkg::OP_POP_FRONT, $urandom);
    wait_for_results();
  endtask

  // The receiver stops for a long stretch while the sender offers words back to back.
  // Once the output register is full, the block must hold in_ready low, and no word
  // may be lost or taken twice.
  task automatic test_receiver_hold_off();
    deq_pkg::deq_in_t w;
    src_steady        = 1'b1;
    sink_hold_request = HOLD_OFF_CYCLES;
    repeat (HOLD_OFF_WORDS) begin
      w = random_word(LEAN_EVEN);
      offer_word(w.operation, w.value_in);
    end
    src_steady = 1'b0;
    wait_for_results();
  endtask

  // The random mix. The lean and the idling of each side change every hundred words.
  // Now and then the sender pauses until every result has come back.
  task automatic test_random_mix();
    deq_pkg::deq_in_t w;
    lean_t lean;
    lean = LEAN_EVEN;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        lean        = lean_t'($urandom_range(0, 2));
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      if (n % 300 == 150) wait_for_results();
      w = random_word(lean);
      offer_word(w.operation, w.value_in);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    out_ready         = 1'b0;
    src_steady        = 1'b0;
    sink_steady       = 1'b0;
    sink_hold_request = 0;
    sink_stall_left   = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    model_fill        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_directed_ops();
    test_fill_and_drain();
    test_receiver_hold_off();
    test_random_mix();

    // The tail wait lets any stray result word show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
